// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the default clock and reset of the block.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/twtw_pkg.sv =====
`default_nettype none

package twtw_pkg;

  localparam int NUM_SECONDS      = 64;
  localparam int SLOTS_PER_SECOND = 16;
  localparam int MAX_TIMERS       = 32;

  localparam int MsPerSec = 1000;
  localparam int SubMs    = MsPerSec / SLOTS_PER_SECOND;
  localparam int SpanMs   = NUM_SECONDS * MsPerSec;

  localparam int TIME_W  = 48;
  localparam int SLOT_W  = 10;
  localparam int SEQ_W   = 32;
  localparam int ID_W    = 42;
  localparam int CNT_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MS_W    = 10;
  localparam int SUB_W   = 4;
  localparam int IVL_W   = 16;
  localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int DSTEP_W = 1;
  localparam int DIV_STEPS = 2;

  // Time modulo the wheel span, and its split into seconds by a reciprocal.
  localparam int FMOD_W   = 17;
  localparam int QT_W     = 8;
  localparam int RECIP_SH = 26;
  localparam int RECIP_K  = (2**RECIP_SH + MsPerSec - 1) / MsPerSec;

  localparam logic [SEQ_W-1:0] SEQ_WRAP = 32'hFFFF_FFFE;

  localparam logic [1:0] KIND_ADDED    = 2'd0;
  localparam logic [1:0] KIND_EXPIRED  = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [IVL_W-1:0] interval_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  tmr_id;
    logic [CNT_W-1:0] live_count;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_REM,
    OP_ADD,
    OP_REJECT,
    OP_SCAN,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
    logic             use_target;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_tick;
    logic reject;
    logic hit;
    logic slots_differ;
  } dp_status_t;

  // Sub-slot of a millisecond within its second, saturated at the last slot.
  function automatic logic [SUB_W-1:0] sub_slot(input logic [MS_W-1:0] ms);
    logic [SUB_W-1:0] sub;
    sub = '0;
    for (int k = 1; k < SLOTS_PER_SECOND; k++) begin
      if (ms >= MS_W'(k * SubMs)) begin
        sub = SUB_W'(k);
      end
    end
    return sub;
  endfunction

endpackage

`default_nettype wire

// ===== src/twtw_dp.sv =====
`default_nettype none

module twtw_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  twtw_pkg::in_item_t   in_item_i,
  input  twtw_pkg::dp_cmd_t    cmd_i,
  output twtw_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output twtw_pkg::out_item_t  out_item_o
);

  `include "assert_macros.svh"

  logic [twtw_pkg::TIME_W-1:0]  now_q, now_d;
  logic [twtw_pkg::FMOD_W-1:0]  rnow_q, rnow_d;
  logic [twtw_pkg::SLOT_W-1:0]  scan_slot_q, scan_slot_d;
  logic [twtw_pkg::SEQ_W-1:0]   seq_q, seq_d;
  logic [twtw_pkg::CNT_W-1:0]   live_q, live_d;
  logic [twtw_pkg::MAX_TIMERS-1:0] valid_q, valid_d;
  logic [twtw_pkg::TIME_W-1:0]  expire_q [twtw_pkg::MAX_TIMERS];
  logic [twtw_pkg::ID_W-1:0]    id_q [twtw_pkg::MAX_TIMERS];

  twtw_pkg::in_item_t           item_q;
  logic [twtw_pkg::TIME_W-1:0]  f_q;
  logic [twtw_pkg::FMOD_W-1:0]  fmod_q, fmod_c;
  logic [twtw_pkg::MS_W-1:0]    rem_q, rem_d;
  logic [twtw_pkg::QT_W-1:0]    quot_q, quot_d;

  logic                         out_valid_q, out_valid_d;
  twtw_pkg::out_item_t          out_q, out_d;

  logic [twtw_pkg::IVL_W-1:0]   incr;
  logic [twtw_pkg::TIME_W:0]    sum_x;
  logic [twtw_pkg::TIME_W-1:0]  sum;
  logic [twtw_pkg::FMOD_W-1:0]  rsum;
  logic [2*twtw_pkg::FMOD_W-1:0] prod;
  logic [twtw_pkg::SLOT_W-1:0]  slot_c, cur_slot;
  logic [twtw_pkg::IDX_W-1:0]   free_ix;
  logic                         found;
  logic                         out_free, hit, reject, emit, wr_en;

  assign incr  = (in_item_i.cmd == twtw_pkg::CMD_TICK) ? twtw_pkg::IVL_W'(1)
                                                        : in_item_i.interval_ms;
  assign sum_x = {1'b0, now_q} + (twtw_pkg::TIME_W+1)'(incr);
  assign sum   = sum_x[twtw_pkg::TIME_W-1:0];
  assign rsum  = rnow_q + twtw_pkg::FMOD_W'(incr);

  // The new time modulo the wheel span. When the 48-bit sum wraps, the
  // wrapped value is already below the largest delay and needs no reduction.
  always_comb begin
    if (sum_x[twtw_pkg::TIME_W]) begin
      fmod_c = sum[twtw_pkg::FMOD_W-1:0];
    end else if (rsum >= twtw_pkg::FMOD_W'(twtw_pkg::SpanMs)) begin
      fmod_c = rsum - twtw_pkg::FMOD_W'(twtw_pkg::SpanMs);
    end else begin
      fmod_c = rsum;
    end
  end

  // Seconds by reciprocal multiplication, exact for every value below 2^17;
  // the millisecond remainder follows in the next cycle.
  assign prod   = (2*twtw_pkg::FMOD_W)'(fmod_q) * (2*twtw_pkg::FMOD_W)'(twtw_pkg::RECIP_K);
  assign quot_d = prod[twtw_pkg::RECIP_SH +: twtw_pkg::QT_W];
  assign rem_d  = twtw_pkg::MS_W'(fmod_q - twtw_pkg::FMOD_W'(quot_q)
                                  * twtw_pkg::FMOD_W'(twtw_pkg::MsPerSec));

  assign slot_c = twtw_pkg::SLOT_W'(quot_q[twtw_pkg::SEC_W-1:0])
                * twtw_pkg::SLOT_W'(twtw_pkg::SLOTS_PER_SECOND)
                + twtw_pkg::SLOT_W'(twtw_pkg::sub_slot(rem_q));

  always_comb begin
    free_ix = '0;
    found   = 1'b0;
    for (int i = 0; i < twtw_pkg::MAX_TIMERS; i++) begin
      if (!found && !valid_q[i]) begin
        free_ix = twtw_pkg::IDX_W'(i);
        found   = 1'b1;
      end
    end
  end

  assign cur_slot = cmd_i.use_target ? slot_c : scan_slot_q;
  assign hit = valid_q[cmd_i.idx]
            && (id_q[cmd_i.idx][twtw_pkg::ID_W-1:twtw_pkg::SEQ_W] == cur_slot)
            && (expire_q[cmd_i.idx] <= now_q);
  assign reject = (item_q.cmd == twtw_pkg::CMD_ADD)
               && ((item_q.interval_ms == '0)
               || ({1'b0, item_q.interval_ms} > (twtw_pkg::IVL_W+1)'(twtw_pkg::SpanMs))
               || (live_q >= twtw_pkg::CNT_W'(twtw_pkg::MAX_TIMERS)));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    now_d       = now_q;
    rnow_d      = rnow_q;
    scan_slot_d = scan_slot_q;
    seq_d       = seq_q;
    live_d      = live_q;
    valid_d     = valid_q;
    emit        = 1'b0;
    wr_en       = 1'b0;
    out_d       = out_q;
    unique case (cmd_i.op)
      twtw_pkg::OP_LOAD: begin
        if (in_item_i.cmd == twtw_pkg::CMD_TICK) begin
          now_d  = sum;
          rnow_d = fmod_c;
        end
      end
      twtw_pkg::OP_ADD: begin
        if (out_free) begin
          wr_en            = 1'b1;
          valid_d[free_ix] = 1'b1;
          live_d           = live_q + twtw_pkg::CNT_W'(1);
          seq_d            = seq_q + twtw_pkg::SEQ_W'(1);
          if (seq_d == twtw_pkg::SEQ_WRAP) begin
            seq_d = twtw_pkg::SEQ_W'(1);
          end
          emit  = 1'b1;
          out_d = '{kind: twtw_pkg::KIND_ADDED, tmr_id: {slot_c, seq_q},
                    live_count: live_d, last: 1'b1};
        end
      end
      twtw_pkg::OP_REJECT: begin
        if (out_free) begin
          emit  = 1'b1;
          out_d = '{kind: twtw_pkg::KIND_REJECTED, tmr_id: '0,
                    live_count: live_q, last: 1'b1};
        end
      end
      twtw_pkg::OP_SCAN: begin
        if (out_free && hit) begin
          valid_d[cmd_i.idx] = 1'b0;
          if (live_q != '0) begin
            live_d = live_q - twtw_pkg::CNT_W'(1);
          end
          emit  = 1'b1;
          out_d = '{kind: twtw_pkg::KIND_EXPIRED, tmr_id: id_q[cmd_i.idx],
                    live_count: live_d, last: 1'b0};
        end
      end
      twtw_pkg::OP_DONE: begin
        if (out_free) begin
          scan_slot_d = slot_c;
          emit        = 1'b1;
          out_d       = '{kind: twtw_pkg::KIND_DONE, tmr_id: '0,
                          live_count: live_q, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      rnow_q      <= '0;
      scan_slot_q <= '0;
      seq_q       <= twtw_pkg::SEQ_W'(1);
      live_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      quot_q      <= '0;
    end else begin
      now_q       <= now_d;
      rnow_q      <= rnow_d;
      scan_slot_q <= scan_slot_d;
      seq_q       <= seq_d;
      live_q      <= live_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.op == twtw_pkg::OP_LOAD) begin
        rem_q  <= '0;
        quot_q <= '0;
      end else if (cmd_i.op == twtw_pkg::OP_DIV) begin
        quot_q <= quot_d;
      end else if (cmd_i.op == twtw_pkg::OP_REM) begin
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == twtw_pkg::OP_LOAD) begin
      item_q <= in_item_i;
      f_q    <= sum;
      fmod_q <= fmod_c;
    end
    if (wr_en) begin
      expire_q[free_ix] <= f_q;
      id_q[free_ix]     <= {slot_c, seq_q};
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign status_o = '{out_free: out_free, is_tick: (item_q.cmd == twtw_pkg::CMD_TICK),
                      reject: reject, hit: hit, slots_differ: (slot_c != scan_slot_q)};
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_DEF(a_live_matches_valid,
    live_q == twtw_pkg::CNT_W'($countones(valid_q)), "live count disagrees with valid entries")
  `ASSERT_DEF(a_rem_in_range,
    rem_q < twtw_pkg::MS_W'(twtw_pkg::MsPerSec), "millisecond remainder out of range")
  `ASSERT_DEF(a_add_has_room,
    (cmd_i.op == twtw_pkg::OP_ADD) |-> found, "add issued with no free entry")

endmodule

`default_nettype wire

// ===== src/twtw_ctrl.sv =====
`default_nettype none

module twtw_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  twtw_pkg::dp_status_t status_i,
  output twtw_pkg::dp_cmd_t    cmd_o
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADD,
    ST_REJ,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_DONE
  } state_e;

  localparam logic [twtw_pkg::DSTEP_W-1:0] LastStep = twtw_pkg::DSTEP_W'(twtw_pkg::DIV_STEPS - 1);
  localparam logic [twtw_pkg::IDX_W-1:0]   LastIdx  = twtw_pkg::IDX_W'(twtw_pkg::MAX_TIMERS - 1);

  state_e                       state_q;
  logic [twtw_pkg::DSTEP_W-1:0] step_q;
  logic [twtw_pkg::IDX_W-1:0]   idx_q;
  logic                         advance;

  assign in_ready_o = (state_q == ST_IDLE);
  // A scan position moves on once its entry is not due or the output register can take its result.
  assign advance = !status_i.hit || status_i.out_free;

  always_comb begin
    cmd_o = '{op: twtw_pkg::OP_NONE, idx: idx_q, use_target: (state_q == ST_SCAN_B)};
    unique case (state_q)
      ST_IDLE:   cmd_o.op = in_valid_i ? twtw_pkg::OP_LOAD : twtw_pkg::OP_NONE;
      ST_DIV:    cmd_o.op = (step_q == LastStep) ? twtw_pkg::OP_REM : twtw_pkg::OP_DIV;
      ST_ADD:    cmd_o.op = twtw_pkg::OP_ADD;
      ST_REJ:    cmd_o.op = twtw_pkg::OP_REJECT;
      ST_SCAN_A: cmd_o.op = twtw_pkg::OP_SCAN;
      ST_SCAN_B: cmd_o.op = twtw_pkg::OP_SCAN;
      ST_DONE:   cmd_o.op = twtw_pkg::OP_DONE;
      default:   cmd_o.op = twtw_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DIV;
            step_q  <= '0;
          end
        end
        ST_DIV: begin
          step_q <= step_q + twtw_pkg::DSTEP_W'(1);
          if (step_q == LastStep) begin
            idx_q <= '0;
            if (status_i.is_tick) begin
              state_q <= ST_SCAN_A;
            end else if (status_i.reject) begin
              state_q <= ST_REJ;
            end else begin
              state_q <= ST_ADD;
            end
          end
        end
        ST_ADD, ST_REJ, ST_DONE: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN_A: begin
          if (advance) begin
            idx_q <= idx_q + twtw_pkg::IDX_W'(1);
            if (idx_q == LastIdx) begin
              idx_q   <= '0;
              state_q <= status_i.slots_differ ? ST_SCAN_B : ST_DONE;
            end
          end
        end
        ST_SCAN_B: begin
          if (advance) begin
            idx_q <= idx_q + twtw_pkg::IDX_W'(1);
            if (idx_q == LastIdx) begin
              idx_q   <= '0;
              state_q <= ST_DONE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_DEF(a_step_only_in_div,
    (state_q != ST_DIV) |=> (state_q != ST_DIV) || (step_q == '0),
    "division entered with a stale step count")
  `ASSERT_DEF(a_div_exit,
    (state_q == ST_DIV && step_q == LastStep) |=> (state_q != ST_DIV),
    "division ran past its last step")
  `ASSERT_DEF(a_scan_from_div,
    $rose(state_q == ST_SCAN_A) |-> $past(state_q == ST_DIV),
    "scan started without a finished division")

endmodule

`default_nettype wire

// ===== src/two_level_timing_wheel.sv =====
// Two-level millisecond timing wheel.
// Input channel (in_valid_i / in_ready_o / in_item_i): an add carries a delay
// in ms, a tick advances time by one millisecond. One item is in work at a time.
// Output channel (out_valid_o / out_ready_i / out_item_o): an add gives one
// result (added with its timer id, or rejected with id 0). A tick gives one
// expired result per due timer in the previous and current slot, then a done
// result; the final result of each item has last set.
// Every item is first loaded on its transfer, then the new time is split into
// second and millisecond in a quotient step and a remainder step. An add or a
// rejection then registers its result once the output register is free, and
// the block returns to idle for the next transfer.
// A tick walks the 32 table entries for the previous slot, and again for the
// current slot when the slot changes, one entry per cycle, then gives the
// done result.
// A result sits in an output register; the next item is accepted while it
// waits. When the receiver stalls, the walk holds on the due entry until the
// pending result transfers.
// Reset clears time, the scan position, the table and the output valid flag;
// the sequence number restarts at 1.
`default_nettype none

module two_level_timing_wheel (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  twtw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output twtw_pkg::out_item_t out_item_o
);

  twtw_pkg::dp_cmd_t    cmd;
  twtw_pkg::dp_status_t status;

  twtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  twtw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
